>>> hdl/pbc_pkg.sv
// Shared types and constants of the PID balance controller
`timescale 1ns / 1ps

package pbc_pkg;

  // payload widths
  localparam int SAMPLE_W    = 10;
  localparam int DEV_W       = 11;
  localparam int DER_W       = 12;
  localparam int DRIVE_W     = 8;
  localparam int INTEG_OUT_W = 20;
  localparam int GAIN_W      = 4;
  localparam int DIV_W       = 4;

  // configuration channel
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR  = 3'd5;

  // register reset values
  localparam logic [SAMPLE_W-1:0] SETPOINT_RST = 10'd0;
  localparam logic [GAIN_W-1:0]   KP_RST       = 4'd5;
  localparam logic [GAIN_W-1:0]   KI_RST       = 4'd1;
  localparam logic [GAIN_W-1:0]   KD_RST       = 4'd2;
  localparam logic                KEEP_RST     = 1'b1;
  localparam logic [DIV_W-1:0]    DIVISOR_RST  = 4'd1;

  // drive saturation limit
  localparam int DRIVE_MAX = 100;

  typedef struct packed {
    logic [SAMPLE_W-1:0] setpoint;
    logic [GAIN_W-1:0]   kp;
    logic [GAIN_W-1:0]   ki;
    logic [GAIN_W-1:0]   kd;
    logic                keep;
    logic [DIV_W-1:0]    divisor;
  } cfg_t;

  typedef enum logic [1:0] {
    MAC_P = 2'd0,
    MAC_I = 2'd1,
    MAC_D = 2'd2
  } mac_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     load_in;
    logic     calc_int;
    logic     div_step;
    logic     div_load;
    logic     mac_en;
    mac_sel_e mac_sel;
    logic     finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic need_div;
    logic div_last;
  } sts_t;

endpackage

>>> hdl/pbc_stream_if.sv
// Handshake channel interfaces of the PID balance controller
`timescale 1ns / 1ps

interface pbc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [pbc_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, mode, sample, input ready);
  modport sink   (input valid, mode, sample, output ready);
endinterface

interface pbc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pbc_pkg::DRIVE_W-1:0]     drive;
  logic                                 drive_clipped;
  logic signed [pbc_pkg::DEV_W-1:0]       prop_error;
  logic signed [pbc_pkg::INTEG_OUT_W-1:0] integ_error;
  logic signed [pbc_pkg::DER_W-1:0]       deriv_error;

  modport source (output valid, drive, drive_clipped, prop_error, integ_error, deriv_error,
                  input ready);
  modport sink   (input valid, drive, drive_clipped, prop_error, integ_error, deriv_error,
                  output ready);
endinterface

interface pbc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pbc_pkg::CFG_IDX_W-1:0]  index;
  logic [pbc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/pbc_cfg_regs.sv
// Configuration register file of the PID balance controller
`timescale 1ns / 1ps

module pbc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [pbc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pbc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           cfg_ready_o,
  output pbc_pkg::cfg_t                  cfg_o
);
  import pbc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // decode the register index, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SETPOINT: cfg_d.setpoint = cfg_data_i[SAMPLE_W-1:0];
        REG_KP:       cfg_d.kp       = cfg_data_i[GAIN_W-1:0];
        REG_KI:       cfg_d.ki       = cfg_data_i[GAIN_W-1:0];
        REG_KD:       cfg_d.kd       = cfg_data_i[GAIN_W-1:0];
        REG_KEEP:     cfg_d.keep     = cfg_data_i[0];
        REG_DIVISOR:  cfg_d.divisor  = cfg_data_i[DIV_W-1:0];
        default:      cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint <= SETPOINT_RST;
      cfg_q.kp       <= KP_RST;
      cfg_q.ki       <= KI_RST;
      cfg_q.kd       <= KD_RST;
      cfg_q.keep     <= KEEP_RST;
      cfg_q.divisor  <= DIVISOR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hdl/pbc_datapath.sv
// Datapath of the PID balance controller: error terms, integral divider, gain MAC
`timescale 1ns / 1ps

module pbc_datapath #(
  parameter int INTEGRAL_BITS = 20
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pbc_pkg::cfg_t                          cfg_i,
  input  logic                                   in_mode_i,
  input  logic [pbc_pkg::SAMPLE_W-1:0]           in_sample_i,
  input  pbc_pkg::cmd_t                          cmd_i,
  output pbc_pkg::sts_t                          sts_o,
  output logic signed [pbc_pkg::DRIVE_W-1:0]     drive_o,
  output logic                                   drive_clipped_o,
  output logic signed [pbc_pkg::DEV_W-1:0]       prop_error_o,
  output logic signed [pbc_pkg::INTEG_OUT_W-1:0] integ_error_o,
  output logic signed [pbc_pkg::DER_W-1:0]       deriv_error_o
);
  import pbc_pkg::*;

  localparam int IB    = INTEGRAL_BITS;
  localparam int ACC_W = IB + 6;
  localparam int CNT_W = $clog2(IB);
  localparam int EXT_W = (IB > INTEG_OUT_W) ? IB : INTEG_OUT_W;

  localparam logic signed [IB:0] INT_LIM  = $signed({2'b00, {(IB-1){1'b1}}});
  localparam logic signed [IB:0] INT_NLIM = -INT_LIM;

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(DRIVE_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX;

  localparam logic signed [DRIVE_W-1:0] DRV_MAX = DRIVE_W'(DRIVE_MAX);
  localparam logic signed [DRIVE_W-1:0] DRV_MIN = -DRV_MAX;

  logic                    mode_q;
  logic signed [DEV_W-1:0] dev_q;
  logic signed [DER_W-1:0] der_q;
  logic signed [DEV_W-1:0] last_dev_q;
  logic signed [IB-1:0]    int_q;
  logic [DIV_W-1:0]        rem_q;
  logic [IB-1:0]           quo_q;
  logic                    neg_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;

  logic signed [DRIVE_W-1:0]     drive_q;
  logic                          clip_q;
  logic signed [DEV_W-1:0]       prop_q;
  logic signed [INTEG_OUT_W-1:0] integ_q;
  logic signed [DER_W-1:0]       deriv_q;

  logic signed [DEV_W-1:0] dev_calc;
  logic signed [DER_W-1:0] der_calc;
  logic signed [IB:0]      keep_op, int_sum, int_sat, int_mag;
  logic [DIV_W:0]          rem_shift;
  logic                    rem_ge;
  logic [DIV_W-1:0]        rem_d;
  logic [IB-1:0]           quo_d;
  logic signed [IB-1:0]    quo_signed;
  logic signed [ACC_W-1:0] mac_op, mac_prod;
  logic [GAIN_W-1:0]       mac_gain;
  logic signed [DRIVE_W-1:0] drive_sat;
  logic                    clip_sat;
  logic signed [EXT_W-1:0] int_ext;

  // deviation and derivative from the incoming sample
  assign dev_calc = $signed({1'b0, in_sample_i}) - $signed({1'b0, cfg_i.setpoint});
  assign der_calc = DER_W'(dev_calc) - DER_W'(last_dev_q);

  // integral update with symmetric saturation
  assign keep_op = cfg_i.keep ? (IB+1)'(int_q) : '0;
  assign int_sum = keep_op + (IB+1)'(dev_q);

  always_comb begin
    priority if (int_sum > INT_LIM) begin
      int_sat = INT_LIM;
    end else if (int_sum < INT_NLIM) begin
      int_sat = INT_NLIM;
    end else begin
      int_sat = int_sum;
    end
  end

  assign int_mag = int_sat[IB] ? -int_sat : int_sat;

  // restoring divider step, one quotient bit a cycle
  assign rem_shift = {rem_q, quo_q[IB-1]};
  assign rem_ge    = rem_shift >= {1'b0, cfg_i.divisor};
  assign rem_d     = rem_ge ? DIV_W'(rem_shift - {1'b0, cfg_i.divisor}) : rem_shift[DIV_W-1:0];
  assign quo_d     = {quo_q[IB-2:0], rem_ge};
  assign quo_signed = neg_q ? -$signed(quo_q) : $signed(quo_q);

  // gain multiply and accumulate, one term a cycle
  always_comb begin
    unique case (cmd_i.mac_sel)
      MAC_P: begin
        mac_op   = ACC_W'(dev_q);
        mac_gain = cfg_i.kp;
      end
      MAC_I: begin
        mac_op   = ACC_W'(int_q);
        mac_gain = cfg_i.ki;
      end
      MAC_D: begin
        mac_op   = ACC_W'(der_q);
        mac_gain = cfg_i.kd;
      end
      default: begin
        mac_op   = '0;
        mac_gain = '0;
      end
    endcase
  end

  assign mac_prod = ACC_W'(mac_op * $signed({1'b0, mac_gain}));
  assign acc_d    = (cmd_i.mac_sel == MAC_P) ? mac_prod : acc_q + mac_prod;

  // drive saturation
  always_comb begin
    priority if (acc_q > ACC_MAX) begin
      drive_sat = DRV_MAX;
      clip_sat  = 1'b1;
    end else if (acc_q < ACC_MIN) begin
      drive_sat = DRV_MIN;
      clip_sat  = 1'b1;
    end else begin
      drive_sat = acc_q[DRIVE_W-1:0];
      clip_sat  = 1'b0;
    end
  end

  // integral as reported: sign extended or low bits
  assign int_ext = EXT_W'(int_q);

  // status
  assign sts_o.is_clear = mode_q;
  assign sts_o.need_div = (dev_q == '0) && (cfg_i.divisor > DIV_W'(1));
  assign sts_o.div_last = cnt_q == CNT_W'(IB - 1);

  // persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_dev_q <= '0;
      int_q      <= '0;
    end else begin
      if (cmd_i.load_in && !in_mode_i) begin
        last_dev_q <= dev_calc;
      end
      priority if (cmd_i.finish && mode_q) begin
        int_q <= '0;
      end else if (cmd_i.calc_int) begin
        int_q <= int_sat[IB-1:0];
      end else if (cmd_i.div_load) begin
        int_q <= quo_signed;
      end else begin
        int_q <= int_q;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= in_mode_i;
      dev_q  <= dev_calc;
      der_q  <= der_calc;
    end
    if (cmd_i.calc_int) begin
      quo_q <= int_mag[IB-1:0];
      neg_q <= int_sat[IB];
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.mac_en) begin
      acc_q <= acc_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (mode_q) begin
        drive_q <= '0;
        clip_q  <= 1'b0;
        prop_q  <= '0;
        integ_q <= '0;
        deriv_q <= '0;
      end else begin
        drive_q <= drive_sat;
        clip_q  <= clip_sat;
        prop_q  <= dev_q;
        integ_q <= int_ext[INTEG_OUT_W-1:0];
        deriv_q <= der_q;
      end
    end
  end

  assign drive_o         = drive_q;
  assign drive_clipped_o = clip_q;
  assign prop_error_o    = prop_q;
  assign integ_error_o   = integ_q;
  assign deriv_error_o   = deriv_q;

endmodule

>>> hdl/pbc_ctrl.sv
// Sequencing state machine of the PID balance controller
`timescale 1ns / 1ps

module pbc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  pbc_pkg::sts_t sts_i,
  output pbc_pkg::cmd_t cmd_o
);
  import pbc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_INT  = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_DFIX = 8'b0000_1000,
    S_MP   = 8'b0001_0000,
    S_MI   = 8'b0010_0000,
    S_MD   = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mac_sel = MAC_P;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_INT;
        end
      end
      S_INT: begin
        if (sts_i.is_clear) begin
          state_d = S_FIN;
        end else begin
          cmd_o.calc_int = 1'b1;
          state_d        = sts_i.need_div ? S_DIV : S_MP;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DFIX;
        end
      end
      S_DFIX: begin
        cmd_o.div_load = 1'b1;
        state_d        = S_MP;
      end
      S_MP: begin
        cmd_o.mac_en  = 1'b1;
        cmd_o.mac_sel = MAC_P;
        state_d       = S_MI;
      end
      S_MI: begin
        cmd_o.mac_en  = 1'b1;
        cmd_o.mac_sel = MAC_I;
        state_d       = S_MD;
      end
      S_MD: begin
        cmd_o.mac_en  = 1'b1;
        cmd_o.mac_sel = MAC_D;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result register occupancy
  always_comb begin
    priority if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/pid_balance_controller.sv
// Top level of the PID balance controller
`timescale 1ns / 1ps

// Discrete PID drive computation, one light-sensor sample per request.
// Channels: cfg_i writes a register (index 0 setpoint, 1..3 kp/ki/kd gains,
// 4 integral keep, 5 integral divisor) and is always ready; write it only
// while no request is in flight. in_i carries mode and sample, out_o
// returns drive, clip flag and the P, I and D error terms, one per request.
// A control request steps from acceptance through the integral, the P, I
// and D MAC steps and the result load; when the deviation is zero and the
// divisor exceeds one, the restoring divider, one quotient bit per cycle,
// and a fix-up step come between the integral and the MAC steps. A clear
// request skips the integral and MAC steps and goes to the result load.
// The result is valid in the cycle after its load step. One request is
// worked on at a time.
// The result sits in an output register, so the next request is accepted
// while it waits; if the receiver stalls, the following result waits in
// the last step until the register is free.
// Reset returns the registers to their defaults and clears the integral and
// the stored previous deviation.

module pid_balance_controller #(
  parameter int INTEGRAL_BITS = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbc_cfg_if.sink   cfg_i,
  pbc_in_if.sink    in_i,
  pbc_out_if.source out_o
);
  import pbc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // configuration registers
  pbc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_i.ready),
    .cfg_o       (cfg)
  );

  // sequencer
  pbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic
  pbc_datapath #(
    .INTEGRAL_BITS (INTEGRAL_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_mode_i       (in_i.mode),
    .in_sample_i     (in_i.sample),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .drive_o         (out_o.drive),
    .drive_clipped_o (out_o.drive_clipped),
    .prop_error_o    (out_o.prop_error),
    .integ_error_o   (out_o.integ_error),
    .deriv_error_o   (out_o.deriv_error)
  );

endmodule

>>> tb/pbc_tb_pkg.sv
// Codes shared by the PID balance controller testbench and its checker
`timescale 1ns / 1ps

package pbc_tb_pkg;

  // request modes
  localparam logic MODE_CONTROL = 1'b0;
  localparam logic MODE_CLEAR   = 1'b1;

  // register indexes past the last register, writes there are dropped
  localparam logic [pbc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [pbc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

endpackage

>>> tb/pbc_drive_checker.sv
// Checker that predicts and compares the PID drive results
`timescale 1ns / 1ps

module pbc_drive_checker #(
  parameter int INTEGRAL_BITS = 20
) (
  input  logic clk_i,
  input  logic rst_ni,
  pbc_cfg_if   cfg_i,
  pbc_in_if    in_i,
  pbc_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   clipped_o,
  output int   integ_sat_o
);
  import pbc_pkg::*;
  import pbc_tb_pkg::*;

  localparam longint INTEG_LIM   = (longint'(1) << (INTEGRAL_BITS - 1)) - 1;
  localparam int     MAX_PRINTED = 20;

  typedef struct packed {
    logic signed [DRIVE_W-1:0]     drive;
    logic                          clipped;
    logic signed [DEV_W-1:0]       prop;
    logic signed [INTEG_OUT_W-1:0] integ;
    logic signed [DER_W-1:0]       deriv;
  } drive_result_t;

  // predicted register copy and controller state
  logic [SAMPLE_W-1:0] sp_reg;
  logic [GAIN_W-1:0]   kp_reg, ki_reg, kd_reg;
  logic                keep_reg;
  logic [DIV_W-1:0]    div_reg;
  longint              prev_dev;
  longint              integ_acc;

  drive_result_t pending_drives[$];
  drive_result_t want;

  task automatic report_mismatch(string what, longint got, longint wanted);
    if (fail_count_o < MAX_PRINTED)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, wanted);
    fail_count_o++;
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SETPOINT: sp_reg   = data[SAMPLE_W-1:0];
      REG_KP:       kp_reg   = data[GAIN_W-1:0];
      REG_KI:       ki_reg   = data[GAIN_W-1:0];
      REG_KD:       kd_reg   = data[GAIN_W-1:0];
      REG_KEEP:     keep_reg = data[0];
      REG_DIVISOR:  div_reg  = data[DIV_W-1:0];
      default: ;
    endcase
  endtask

  // one request: a clear, or a control step with deviation, integral, derivative, saturated drive
  function automatic drive_result_t compute_drive(logic mode, logic [SAMPLE_W-1:0] smp);
    drive_result_t res;
    longint dev, der, integ, raw, drv;
    res = '0;
    if (mode == MODE_CLEAR) begin
      integ_acc = 0;
      return res;
    end
    dev = longint'(smp) - longint'(sp_reg);
    der = dev - prev_dev;
    prev_dev = dev;
    integ = (keep_reg ? integ_acc : 0) + dev;
    if (integ > INTEG_LIM) integ = INTEG_LIM;
    if (integ < -INTEG_LIM) integ = -INTEG_LIM;
    if (integ == INTEG_LIM || integ == -INTEG_LIM) integ_sat_o++;
    // zero deviation shrinks the integral, a divisor of zero acts as one
    if (dev == 0 && div_reg > 1) integ = integ / longint'(div_reg);
    integ_acc = integ;
    raw = longint'(kp_reg) * dev + longint'(ki_reg) * integ + longint'(kd_reg) * der;
    drv = raw;
    if (raw > DRIVE_MAX) begin
      drv = DRIVE_MAX;
      res.clipped = 1'b1;
    end
    if (raw < -DRIVE_MAX) begin
      drv = -DRIVE_MAX;
      res.clipped = 1'b1;
    end
    res.drive = DRIVE_W'(drv);
    res.prop  = DEV_W'(dev);
    res.integ = INTEG_OUT_W'(integ);
    res.deriv = DER_W'(der);
    return res;
  endfunction

  // watch all three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_reg    = SETPOINT_RST;
      kp_reg    = KP_RST;
      ki_reg    = KI_RST;
      kd_reg    = KD_RST;
      keep_reg  = KEEP_RST;
      div_reg   = DIVISOR_RST;
      prev_dev  = 0;
      integ_acc = 0;
      pending_drives.delete();
      pending_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) write_register(cfg_i.index, cfg_i.data);
      if (in_i.valid && in_i.ready)
        pending_drives.push_back(compute_drive(in_i.mode, in_i.sample));
      if (out_i.valid && out_i.ready) begin
        if (pending_drives.size() == 0) begin
          report_mismatch("result with no request pending", out_i.drive, 0);
        end else begin
          want = pending_drives.pop_front();
          if (out_i.drive !== want.drive) report_mismatch("drive", out_i.drive, want.drive);
          if (out_i.drive_clipped !== want.clipped)
            report_mismatch("drive_clipped", out_i.drive_clipped, want.clipped);
          if (out_i.prop_error !== want.prop)
            report_mismatch("prop_error", out_i.prop_error, want.prop);
          if (out_i.integ_error !== want.integ)
            report_mismatch("integ_error", out_i.integ_error, want.integ);
          if (out_i.deriv_error !== want.deriv)
            report_mismatch("deriv_error", out_i.deriv_error, want.deriv);
          checked_o++;
          if (want.clipped) clipped_o++;
        end
      end
      pending_o = pending_drives.size();
    end
  end

endmodule

>>> tb/pid_balance_controller_tb.sv
// Testbench top of the PID balance controller: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module pid_balance_controller_tb;
  import pbc_pkg::*;
  import pbc_tb_pkg::*;

  localparam int INTEGRAL_BITS  = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_PHASES  = 7;
  localparam int SAT_ITEMS      = 560;
  localparam int MIX_ITEMS      = 40;

  logic clk_i;
  logic rst_ni;
  logic in_taken, out_taken, cfg_taken;
  logic no_idle;
  int   fail_count, pending, checked, clipped, integ_sat;
  int   sent, clears, writes, settings;

  pbc_cfg_if cfg_if ();
  pbc_in_if  in_if ();
  pbc_out_if out_if ();

  pid_balance_controller #(.INTEGRAL_BITS(INTEGRAL_BITS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  pbc_drive_checker #(.INTEGRAL_BITS(INTEGRAL_BITS)) u_drive_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_if),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .clipped_o    (clipped),
    .integ_sat_o  (integ_sat)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // handshakes seen at the rising edge, read back at the falling edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      in_taken  <= in_if.valid && in_if.ready;
      out_taken <= out_if.valid && out_if.ready;
      cfg_taken <= cfg_if.valid && cfg_if.ready;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(logic mode, logic [SAMPLE_W-1:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid  = 1'b1;
    in_if.mode   = mode;
    in_if.sample = smp;
    do @(negedge clk_i); while (!in_taken);
    sent++;
    if (mode == MODE_CLEAR) clears++;
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(negedge clk_i); while (!cfg_taken);
    writes++;
  endtask

  // new settings only once every result is back
  task automatic configure(logic [CFG_DATA_W-1:0] sp, kp, ki, kd, keep, dv);
    wait_drained();
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_KEEP, keep);
    write_reg(REG_DIVISOR, dv);
    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_if.valid = 1'b0;
    settings++;
  endtask

  // receiver: ready runs broken by stalls
  initial begin
    int run, stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(1, 24);
      out_if.ready = 1'b1;
      repeat (run) @(negedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if (in_taken || out_taken || cfg_taken) idle = 0;
      else idle++;
    end
    $display("timeout after %0d cycles without progress", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // stimulus
  initial begin
    int ph, i, r, s, n;
    logic [SAMPLE_W-1:0] phase_sp;
    logic high_side;
    in_if.valid  = 1'b0;
    in_if.mode   = MODE_CONTROL;
    in_if.sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    no_idle  = 1'b0;
    sent     = 0;
    clears   = 0;
    writes   = 0;
    settings = 1;
    rst_ni   = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: zero deviation, full swings, clear in between
    send_request(MODE_CONTROL, 10'd0);
    send_request(MODE_CONTROL, 10'd1023);
    send_request(MODE_CONTROL, 10'd0);
    send_request(MODE_CLEAR, 10'd1023);
    send_request(MODE_CONTROL, 10'd512);

    // top gains, integral kept, division on zero deviation both signs
    configure(10'd512, 10'd15, 10'd15, 10'd15, 10'd1, 10'd15);
    send_request(MODE_CONTROL, 10'd1023);
    send_request(MODE_CONTROL, 10'd1023);
    send_request(MODE_CONTROL, 10'd512);
    send_request(MODE_CONTROL, 10'd0);
    send_request(MODE_CONTROL, 10'd512);
    send_request(MODE_CLEAR, 10'd0);
    send_request(MODE_CONTROL, 10'd512);

    // integral dropped each step, setpoint at top, divisor zero
    configure(10'd1023, 10'd3, 10'd7, 10'd1, 10'd0, 10'd0);
    send_request(MODE_CONTROL, 10'd700);
    send_request(MODE_CONTROL, 10'd700);
    send_request(MODE_CONTROL, 10'd1023);
    send_request(MODE_CONTROL, 10'd300);

    // all gains zero, register data with upper bits set
    configure(10'd0, 10'h3F0, 10'h3F0, 10'h3F0, 10'h3FE, 10'h3F1);
    send_request(MODE_CONTROL, 10'd1023);
    send_request(MODE_CONTROL, 10'd0);
    send_request(MODE_CONTROL, 10'd0);

    // random part: two phases drive the integral into its limits, the rest mix
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      no_idle = (ph == 2 || ph == 5);
      if (ph < 2) begin
        high_side = (ph == 0);
        phase_sp  = high_side ? 10'd0 : 10'd1023;
        configure(phase_sp, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), 10'h3FF, high_side ? 10'd0 : 10'h3F1);
        n = SAT_ITEMS;
      end else begin
        r = $urandom_range(0, 9);
        phase_sp = (r == 0) ? 10'd0 : (r == 1) ? 10'd1023 : SAMPLE_W'($urandom);
        configure(phase_sp, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        n = MIX_ITEMS;
      end
      for (i = 0; i < n; i++) begin
        // halfway through, the sender holds off until every result is back
        if (i == n / 2) wait_drained();
        r = $urandom_range(0, 99);
        if (ph < 2) begin
          if (r < 96) send_request(MODE_CONTROL, high_side ? 10'd1023 : 10'd0);
          else if (r < 98) send_request(MODE_CONTROL, phase_sp);
          else send_request(MODE_CONTROL, SAMPLE_W'($urandom));
        end else if (r < 8) begin
          send_request(MODE_CLEAR, SAMPLE_W'($urandom));
        end else if (r < 30) begin
          send_request(MODE_CONTROL, phase_sp);
        end else if (r < 70) begin
          s = int'(phase_sp) + int'($urandom_range(0, 30)) - 15;
          if (s < 0) s = 0;
          if (s > 1023) s = 1023;
          send_request(MODE_CONTROL, SAMPLE_W'(s));
        end else begin
          send_request(MODE_CONTROL, SAMPLE_W'($urandom));
        end
      end
    end

    no_idle = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("covered %0d requests (%0d clears) under %0d settings, %0d register writes",
             sent, clears, settings, writes);
    $display("checked %0d results: %0d with drive saturated, %0d with integral at its limit",
             checked, clipped, integ_sat);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
